/* rtl/sprite_entry_draw_expander_top_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef SPRITE_ENTRY_DRAW_EXPANDER_TOP_MACROS_SVH
`define SPRITE_ENTRY_DRAW_EXPANDER_TOP_MACROS_SVH

// Check an implication on every rising clock edge outside of reset.
`define SEDX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication against the state in the following cycle.
`define SEDX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sedx_pkg.sv */
package sedx_pkg;

  localparam logic [7:0] CodeKeepMask = 8'hc0;
  localparam logic [7:0] XOffset      = 8'd39;
  localparam logic [7:0] YInvert      = 8'd1;   // 257 mod 256
  localparam logic [8:0] YOffset      = 9'd32;
  localparam logic [2:0] LastSingle   = 3'd1;
  localparam logic [2:0] LastDouble   = 3'd7;

  // One classified sprite entry, ready for expansion.
  typedef struct packed {
    logic       size;
    logic [7:0] code;
    logic [5:0] color;
    logic       flip_x;
    logic       flip_y;
    logic [7:0] sx;
    logic [8:0] ybase;
  } sedx_desc_t;

endpackage

/* rtl/sedx_front.sv */
module sedx_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                item_valid_i,
  input  logic                queue_full_i,
  input  logic [7:0]          sprite_code_i,
  input  logic [7:0]          sprite_color_i,
  input  logic [7:0]          pos_y_i,
  input  logic [7:0]          pos_x_i,
  input  logic [7:0]          flip_bits_i,
  output logic                desc_push_o,
  output sedx_pkg::sedx_desc_t desc_o
);
  import sedx_pkg::*;

  logic       screen_flip_q, screen_flip_d;
  logic       size;
  logic [7:0] y_wrap;

  always_comb begin
    screen_flip_d = cfg_we_i ? cfg_wdata_i : screen_flip_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_flip_q <= 1'b0;
    end else begin
      screen_flip_q <= screen_flip_d;
    end
  end

  assign size        = sprite_code_i[7];
  assign desc_push_o = item_valid_i && !queue_full_i;

  always_comb begin
    // invert y, lift a double-size sprite by one tile row, wrap to a byte
    y_wrap = YInvert - pos_y_i - {3'b000, size, 4'b0000};
    desc_o.size   = size;
    desc_o.code   = size ? ((sprite_code_i & CodeKeepMask) | {sprite_code_i[5:0], 2'b00})
                         : sprite_code_i;
    desc_o.color  = sprite_color_i[5:0];
    desc_o.flip_x = flip_bits_i[0] ^ screen_flip_q;
    desc_o.flip_y = flip_bits_i[1] ^ screen_flip_q;
    desc_o.sx     = pos_x_i - XOffset;
    desc_o.ybase  = {1'b0, y_wrap} - YOffset;
  end

endmodule

/* rtl/sedx_queue.sv */
module sedx_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  sedx_pkg::sedx_desc_t wr_data_i,
  output logic                 full_o,
  input  logic                 rd_en_i,
  output logic                 valid_o,
  output sedx_pkg::sedx_desc_t rd_data_o
);
  import sedx_pkg::*;
  `include "sprite_entry_draw_expander_top_macros.svh"

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  sedx_desc_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;

  assign full_o    = (count_q == CntFull);
  assign valid_o   = (count_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `SEDX_ASSERT_IMP(a_no_overflow, full_o, !wr_en_i, "queue written while full")
  `SEDX_ASSERT_IMP(a_no_underflow, !valid_o, !rd_en_i, "queue read while empty")

endmodule

/* rtl/sedx_back.sv */
module sedx_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 desc_valid_i,
  input  sedx_pkg::sedx_desc_t desc_i,
  output logic                 desc_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [7:0]           tile_code_o,
  output logic [5:0]           tile_color_o,
  output logic                 tile_flip_x_o,
  output logic                 tile_flip_y_o,
  output logic [8:0]           screen_x_o,
  output logic signed [8:0]    screen_y_o,
  output logic                 last_tile_o
);
  import sedx_pkg::*;
  `include "sprite_entry_draw_expander_top_macros.svh"

  logic [2:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       out_pop, adv, last;
  logic       col, row, copy, qc, qr;
  logic [7:0] tile, x0;
  logic [8:0] y0;

  // count bits: copy, then column, then row
  always_comb begin
    copy = cnt_q[0];
    col  = desc_i.size & cnt_q[1];
    row  = desc_i.size & cnt_q[2];
    qc   = col ^ (desc_i.size & desc_i.flip_x);
    qr   = row ^ (desc_i.size & desc_i.flip_y);
    tile = desc_i.code + {6'b000000, qr, qc};
    x0   = desc_i.sx + {3'b000, col, 4'b0000};
    y0   = desc_i.ybase + {4'b0000, row, 4'b0000};
    last = desc_i.size ? (cnt_q == LastDouble) : (cnt_q == LastSingle);
  end

  assign out_pop    = pop_i && out_valid_q;
  assign adv        = desc_valid_i && (!out_valid_q || out_pop);
  assign desc_pop_o = adv && last;
  assign empty_o    = !out_valid_q;

  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      cnt_d       = last ? '0 : cnt_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (out_pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tile_code_o   <= tile;
      tile_color_o  <= desc_i.color;
      tile_flip_x_o <= desc_i.flip_x;
      tile_flip_y_o <= desc_i.flip_y;
      screen_x_o    <= {copy, x0};
      screen_y_o    <= $signed(y0);
      last_tile_o   <= last;
    end
  end

  `SEDX_ASSERT_IMP(a_cnt_needs_entry, cnt_q != '0, desc_valid_i,
                   "command count running without an entry")
  `SEDX_ASSERT_IMP(a_single_short, desc_valid_i && !desc_i.size, cnt_q[2:1] == 2'b00,
                   "single-size entry counted past two commands")
  `SEDX_ASSERT_NEXT(a_last_restarts, desc_pop_o, cnt_q == '0,
                    "count not cleared after final command")

endmodule

/* rtl/sprite_entry_draw_expander_top.sv */
// Channel   | Handshake          | Payload
// ----------+--------------------+---------------------------------------------
// entry in  | push / full        | sprite_code, sprite_color, pos_y, pos_x, flip
// draw out  | empty / pop        | tile_code, tile_color, flips, x, y, last_tile
// config    | cfg_we_i           | cfg_wdata_i (screen flip)
//
// An entry is classified in the cycle it is taken and queued; the sequencer
// then issues one draw command per cycle, 2 for a 16x16 sprite and 8 for 32x32,
// while pop keeps up; each command is held in the output register for the result.
// Reset clears screen flip, queue and output valid flag, but not output data.
// A stalled pop holds the command; entries keep queuing until the queue fills.
module sprite_entry_draw_expander_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        sprite_code_i,
  input  logic [7:0]        sprite_color_i,
  input  logic [7:0]        pos_y_i,
  input  logic [7:0]        pos_x_i,
  input  logic [7:0]        flip_bits_i,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        tile_code_o,
  output logic [5:0]        tile_color_o,
  output logic              tile_flip_x_o,
  output logic              tile_flip_y_o,
  output logic [8:0]        screen_x_o,
  output logic signed [8:0] screen_y_o,
  output logic              last_tile_o
);
  import sedx_pkg::*;

  sedx_desc_t front_desc, queue_desc;
  logic       desc_push, desc_pop, desc_valid;

  sedx_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .item_valid_i  (push),
    .queue_full_i  (full),
    .sprite_code_i (sprite_code_i),
    .sprite_color_i(sprite_color_i),
    .pos_y_i       (pos_y_i),
    .pos_x_i       (pos_x_i),
    .flip_bits_i   (flip_bits_i),
    .desc_push_o   (desc_push),
    .desc_o        (front_desc)
  );

  sedx_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (desc_push),
    .wr_data_i(front_desc),
    .full_o   (full),
    .rd_en_i  (desc_pop),
    .valid_o  (desc_valid),
    .rd_data_o(queue_desc)
  );

  sedx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_i       (queue_desc),
    .desc_pop_o   (desc_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .tile_code_o  (tile_code_o),
    .tile_color_o (tile_color_o),
    .tile_flip_x_o(tile_flip_x_o),
    .tile_flip_y_o(tile_flip_y_o),
    .screen_x_o   (screen_x_o),
    .screen_y_o   (screen_y_o),
    .last_tile_o  (last_tile_o)
  );

endmodule
